// File: rtl/ladsr_pkg.sv
// Shared types and constants for the linear ADSR envelope block.
package ladsr_pkg;

    localparam int CHANNELS_DEFAULT = 2;

    localparam int LEVEL_W = 24;
    localparam int GAIN_W  = 16;
    localparam int POS_W   = 4;
    localparam int CFG_W   = 24;
    localparam int INDEX_W = 3;

    localparam logic [LEVEL_W-1:0] UNITY_LEVEL = 24'h800000;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;

    // operation codes
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_GATE_ON  = 2'd1;
    localparam logic [1:0] OP_GATE_OFF = 2'd2;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_ATTACK_STEP   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_DECAY_STEP    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_RELEASE_STEP  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [INDEX_W-1:0] REG_OUTPUT_GAIN   = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] sample_in;
    } in_word_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic [23:0]        envelope_level;
    } out_word_t;

endpackage

// File: rtl/linear_adsr_envelope.sv
// Linear ADSR envelope: gate handling, level stepping and shared-multiplier output scaling.
// Sample path: accept, S_MUL_LEVEL, S_MUL_LO, S_MUL_HI (three passes through one shared
// 24x24 multiplier), then S_ROUND rounds/saturates into the output register. Gate words
// produce no output. A new sample word is taken only after S_ROUND; gate words one per
// cycle while the sequencer is idle. A held result stalls only the next sample's round step.
// Reset (rst_n, async low): level 0, stage attack, not gated, channel 0, registers 0, gain 1.0.
module linear_adsr_envelope #(
    parameter int CHANNELS = ladsr_pkg::CHANNELS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ladsr_pkg::in_word_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ladsr_pkg::out_word_t                 out_data,
    input  logic                                 cfg_write,
    input  logic [ladsr_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [ladsr_pkg::CFG_W-1:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LEVEL,
        S_MUL_LO,
        S_MUL_HI,
        S_ROUND
    } seq_state_t;

    typedef enum logic [1:0] {
        ST_ATTACK,
        ST_DECAY,
        ST_SUSTAIN,
        ST_RELEASE
    } env_stage_t;

    localparam logic [ladsr_pkg::POS_W:0] CHAN_LIMIT = (ladsr_pkg::POS_W+1)'(CHANNELS);

    // configuration
    logic [23:0] attack_step_reg;
    logic [23:0] decay_step_reg;
    logic [23:0] release_step_reg;
    logic [23:0] sustain_level_reg;
    logic [15:0] output_gain_reg;

    // sequencer and envelope state
    seq_state_t                   state_reg, state_next;
    env_stage_t                   stage_reg, stage_next;
    logic [23:0]                  level_reg, level_next;
    logic                         gated_reg, gated_next;
    logic [ladsr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                         neg_reg, neg_next;
    logic [23:0]                  mag_reg, mag_next;
    logic [47:0]                  prod_reg, prod_next;
    logic [40:0]                  lo_reg, lo_next;
    logic [63:0]                  sum_reg, sum_next;
    logic                         out_valid_reg, out_valid_next;
    ladsr_pkg::out_word_t         out_word_reg, out_word_next;

    // level step
    logic [23:0]  sus;
    logic [24:0]  attack_sum;
    logic [23:0]  adv_level;
    env_stage_t   adv_stage;
    logic [ladsr_pkg::POS_W:0] pos_inc;

    // shared multiplier
    logic [23:0] mul_a;
    logic [23:0] mul_b;
    logic [47:0] mul_p;

    // rounding
    logic [26:0] rnd;
    logic [23:0] mag_sat;
    logic [23:0] mag_in;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg   <= '0;
            decay_step_reg    <= '0;
            release_step_reg  <= '0;
            sustain_level_reg <= '0;
            output_gain_reg   <= ladsr_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ladsr_pkg::REG_ATTACK_STEP:   attack_step_reg   <= cfg_data;
                ladsr_pkg::REG_DECAY_STEP:    decay_step_reg    <= cfg_data;
                ladsr_pkg::REG_RELEASE_STEP:  release_step_reg  <= cfg_data;
                ladsr_pkg::REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data;
                ladsr_pkg::REG_OUTPUT_GAIN:   output_gain_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // one envelope step, applied when the frame counter wraps
    always_comb
    begin
        sus = (sustain_level_reg > ladsr_pkg::UNITY_LEVEL) ? ladsr_pkg::UNITY_LEVEL
                                                           : sustain_level_reg;
        attack_sum = {1'b0, level_reg} + {1'b0, attack_step_reg};
        adv_level  = level_reg;
        adv_stage  = stage_reg;
        if (gated_reg)
        begin
            if (stage_reg == ST_ATTACK)
            begin
                if (attack_sum >= {1'b0, ladsr_pkg::UNITY_LEVEL})
                begin
                    adv_level = ladsr_pkg::UNITY_LEVEL;
                    adv_stage = ST_DECAY;
                end
                else
                begin
                    adv_level = attack_sum[23:0];
                end
            end
            else if (stage_reg == ST_DECAY)
            begin
                if (decay_step_reg >= level_reg || level_reg - decay_step_reg <= sus)
                begin
                    adv_level = sus;
                    adv_stage = ST_SUSTAIN;
                end
                else
                begin
                    adv_level = level_reg - decay_step_reg;
                end
            end
        end
        else if (stage_reg == ST_RELEASE)
        begin
            if (release_step_reg >= level_reg)
            begin
                adv_level = '0;
                adv_stage = ST_ATTACK;
            end
            else
            begin
                adv_level = level_reg - release_step_reg;
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            S_MUL_LO:
            begin
                mul_a = prod_reg[23:0];
                mul_b = {8'd0, output_gain_reg};
            end
            S_MUL_HI:
            begin
                mul_a = prod_reg[47:24];
                mul_b = {8'd0, output_gain_reg};
            end
            default:
            begin
                mul_a = mag_reg;
                mul_b = level_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        pos_inc = {1'b0, pos_reg} + 1'b1;
        mag_in  = in_data.sample_in[23] ? (~in_data.sample_in + 24'd1) : in_data.sample_in;
        rnd     = sum_reg[63:37];
        if (neg_reg)
        begin
            mag_sat = (rnd > 27'h800000) ? 24'h800000 : rnd[23:0];
        end
        else
        begin
            mag_sat = (rnd > 27'h7FFFFF) ? 24'h7FFFFF : rnd[23:0];
        end

        state_next     = state_reg;
        stage_next     = stage_reg;
        level_next     = level_reg;
        gated_next     = gated_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.operation)
                        ladsr_pkg::OP_GATE_ON:
                        begin
                            gated_next = 1'b1;
                            stage_next = ST_ATTACK;
                            level_next = '0;
                        end
                        ladsr_pkg::OP_GATE_OFF:
                        begin
                            if (gated_reg)
                            begin
                                gated_next = 1'b0;
                                stage_next = ST_RELEASE;
                            end
                        end
                        ladsr_pkg::OP_SAMPLE:
                        begin
                            if (pos_inc >= CHAN_LIMIT)
                            begin
                                pos_next   = '0;
                                level_next = adv_level;
                                stage_next = adv_stage;
                            end
                            else
                            begin
                                pos_next = pos_inc[ladsr_pkg::POS_W-1:0];
                            end
                            neg_next   = in_data.sample_in[23];
                            mag_next   = mag_in;
                            state_next = S_MUL_LEVEL;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL_LEVEL:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                // rounding half folded in here
                lo_next    = {1'b0, mul_p[39:0]} + 41'h10_0000_0000;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                sum_next   = {mul_p[39:0], 24'd0} + {23'd0, lo_reg};
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.sample_out     = neg_reg ? (~mag_sat + 24'd1) : mag_sat;
                    out_word_next.envelope_level = level_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= ST_ATTACK;
            level_reg     <= '0;
            gated_reg     <= 1'b0;
            pos_reg       <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            prod_reg      <= '0;
            lo_reg        <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            level_reg     <= level_next;
            gated_reg     <= gated_next;
            pos_reg       <= pos_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            prod_reg      <= prod_next;
            lo_reg        <= lo_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

endmodule

// File: bench/linear_adsr_envelope_tb.sv
// Self-checking bench for linear_adsr_envelope: random notes vs an envelope tracker.

typedef enum logic [1:0] {
    STAGE_ATTACK,
    STAGE_DECAY,
    STAGE_SUSTAIN,
    STAGE_RELEASE
} env_stage_t;

// Follows level, stage, gate and channel position; queues the scaled words.
class adsr_tracker;
    int unsigned           channels;
    logic [23:0]           attack_step;
    logic [23:0]           decay_step;
    logic [23:0]           release_step;
    logic [23:0]           sustain_level;
    logic [15:0]           output_gain;
    logic [23:0]           level;
    env_stage_t            stage;
    bit                    gated;
    int unsigned           channel_pos;
    ladsr_pkg::out_word_t  envelope_outputs[$];
    int unsigned           mismatches;
    int unsigned           words_seen;

    function new(int unsigned n);
        channels      = n;
        attack_step   = '0;
        decay_step    = '0;
        release_step  = '0;
        sustain_level = '0;
        output_gain   = ladsr_pkg::GAIN_RESET;
        level         = '0;
        stage         = STAGE_ATTACK;
        gated         = 1'b0;
        channel_pos   = 0;
        mismatches    = 0;
        words_seen    = 0;
    endfunction

    function void set_register(logic [ladsr_pkg::INDEX_W-1:0] idx,
                               logic [ladsr_pkg::CFG_W-1:0] val);
        case (idx)
            ladsr_pkg::REG_ATTACK_STEP:   attack_step = val;
            ladsr_pkg::REG_DECAY_STEP:    decay_step = val;
            ladsr_pkg::REG_RELEASE_STEP:  release_step = val;
            ladsr_pkg::REG_SUSTAIN_LEVEL: sustain_level = val;
            ladsr_pkg::REG_OUTPUT_GAIN:   output_gain = val[15:0];
            default: ;
        endcase
    endfunction

    function void step_level();
        logic [23:0] sus;
        logic [24:0] sum;
        sus = (sustain_level > ladsr_pkg::UNITY_LEVEL) ? ladsr_pkg::UNITY_LEVEL
                                                       : sustain_level;
        if (gated)
        begin
            if (stage == STAGE_ATTACK)
            begin
                sum = {1'b0, level} + {1'b0, attack_step};
                if (sum >= {1'b0, ladsr_pkg::UNITY_LEVEL})
                begin
                    level = ladsr_pkg::UNITY_LEVEL;
                    stage = STAGE_DECAY;
                end
                else
                begin
                    level = sum[23:0];
                end
            end
            else if (stage == STAGE_DECAY)
            begin
                if (decay_step >= level || level - decay_step <= sus)
                begin
                    level = sus;
                    stage = STAGE_SUSTAIN;
                end
                else
                begin
                    level = level - decay_step;
                end
            end
        end
        else if (stage == STAGE_RELEASE)
        begin
            if (release_step >= level)
            begin
                level = '0;
                stage = STAGE_ATTACK;
            end
            else
            begin
                level = level - release_step;
            end
        end
    endfunction

    // sample * level * gain, scaled by 2^-37, rounded half away from zero, saturated
    function logic [23:0] scaled_sample(logic [23:0] s);
        logic [24:0] neg_mag;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        logic [24:0] res;
        neg_mag = 25'h1000000 - {1'b0, s};
        mag = s[23] ? 64'(neg_mag) : 64'(s);
        prod = mag * 64'(level) * 64'(output_gain);
        r = (prod + (64'd1 << 36)) >> 37;
        if (s[23])
        begin
            if (r > 64'h800000)
                r = 64'h800000;
            res = 25'h1000000 - r[24:0];
            return res[23:0];
        end
        if (r > 64'h7FFFFF)
            r = 64'h7FFFFF;
        return r[23:0];
    endfunction

    function void take_word(ladsr_pkg::in_word_t w);
        ladsr_pkg::out_word_t want;
        case (w.operation)
            ladsr_pkg::OP_GATE_ON:
            begin
                gated = 1'b1;
                stage = STAGE_ATTACK;
                level = '0;
            end
            ladsr_pkg::OP_GATE_OFF:
            begin
                if (gated)
                begin
                    gated = 1'b0;
                    stage = STAGE_RELEASE;
                end
            end
            ladsr_pkg::OP_SAMPLE:
            begin
                if (channel_pos + 1 >= channels)
                begin
                    channel_pos = 0;
                    step_level();
                end
                else
                begin
                    channel_pos = channel_pos + 1;
                end
                want.sample_out = scaled_sample(w.sample_in);
                want.envelope_level = level;
                envelope_outputs.push_back(want);
            end
            default: ;
        endcase
    endfunction

    task report(string msg);
        if (mismatches < 40)
            $display("MISMATCH word %0d: %s", words_seen, msg);
        mismatches++;
    endtask

    task check_word(ladsr_pkg::out_word_t got);
        ladsr_pkg::out_word_t want;
        words_seen++;
        if (envelope_outputs.size() == 0)
        begin
            report($sformatf("no word pending, got out=%h level=%h",
                             got.sample_out, got.envelope_level));
            return;
        end
        want = envelope_outputs.pop_front();
        if (got.sample_out !== want.sample_out)
            report($sformatf("sample_out %h, want %h", got.sample_out, want.sample_out));
        if (got.envelope_level !== want.envelope_level)
            report($sformatf("envelope_level %h, want %h",
                             got.envelope_level, want.envelope_level));
    endtask

    function int unsigned pending();
        return envelope_outputs.size();
    endfunction
endclass

module linear_adsr_envelope_tb;

    localparam int NUM_CHANNELS  = ladsr_pkg::CHANNELS_DEFAULT;
    localparam int NUM_PHASES    = 14;
    localparam int PHASE_ITEMS   = 85;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 1000000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        PROF_FLOOR,
        PROF_CEILING,
        PROF_UNITY,
        PROF_BRISK,
        PROF_SLOW,
        PROF_WILD
    } profile_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    ladsr_pkg::in_word_t             in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    ladsr_pkg::out_word_t            out_data;
    logic                            cfg_write = 1'b0;
    logic [ladsr_pkg::INDEX_W-1:0]   cfg_index = '0;
    logic [ladsr_pkg::CFG_W-1:0]     cfg_data = '0;

    adsr_tracker tracker;
    int          items_sent = 0;
    int          in_gap_pct = 25;
    int          out_stall_pct = 25;
    bit          hold_request = 1'b0;
    int          cycles = 0;

    logic [23:0] edge_samples [10] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                                        24'h000001, 24'h800001, 24'h7FFFFF, 24'h800000,
                                        24'h400000, 24'hC00000};

    linear_adsr_envelope #(
        .CHANNELS (NUM_CHANNELS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short, some medium, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ladsr_pkg::in_word_t sample_word(logic [23:0] v);
        ladsr_pkg::in_word_t w;
        w.operation = ladsr_pkg::OP_SAMPLE;
        w.sample_in = v;
        return w;
    endfunction

    function automatic ladsr_pkg::in_word_t ctl_word(logic [1:0] op);
        ladsr_pkg::in_word_t w;
        w.operation = op;
        w.sample_in = 24'($urandom);
        return w;
    endfunction

    function automatic logic [23:0] random_sample();
        if ($urandom_range(99) < 85)
            return 24'($urandom);
        return edge_samples[$urandom_range(9)];
    endfunction

    // call at a rising edge; returns at the edge that accepts the word (plus any gap)
    task automatic offer(ladsr_pkg::in_word_t w);
        int gap;
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_word(w);
        if (w.operation != OP_UNUSED)
            items_sent++;
        gap = ($urandom_range(99) < in_gap_pct) ? idle_length() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [ladsr_pkg::INDEX_W-1:0] idx,
                             logic [ladsr_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_register(idx, val);
    endtask

    task automatic program_envelope(logic [23:0] atk, logic [23:0] dec, logic [23:0] rel,
                                    logic [23:0] sus, logic [23:0] gain, bit stray_write);
        write_reg(ladsr_pkg::REG_ATTACK_STEP, atk);
        write_reg(ladsr_pkg::REG_DECAY_STEP, dec);
        write_reg(ladsr_pkg::REG_RELEASE_STEP, rel);
        write_reg(ladsr_pkg::REG_SUSTAIN_LEVEL, sus);
        write_reg(ladsr_pkg::REG_OUTPUT_GAIN, gain);
        // index past the register list must be dropped
        if (stray_write)
            write_reg(ladsr_pkg::REG_OUTPUT_GAIN + 3'($urandom_range(1, 3)), 24'($urandom));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // wait for the pipe to empty, including gate words that leave nothing behind
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("linear_adsr_envelope test failed");
        $finish;
    end

    // output side: checks words, random stalls, long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_word(out_data);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(99) < out_stall_pct)
            begin
                stall_left = idle_length() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int          target;
        int          r;
        int          n_on;
        int          n_off;
        profile_t    prof;
        logic [23:0] atk;
        logic [23:0] dec;
        logic [23:0] rel;
        logic [23:0] sus;
        logic [23:0] gain;

        tracker = new(NUM_CHANNELS);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one full envelope at gain near 4.0 so peaks saturate
        program_envelope(24'h300000, 24'h200000, 24'h300000, 24'h500000, 24'h00FFFF, 1'b1);
        offer(sample_word(24'h7FFFFF));
        offer(ctl_word(ladsr_pkg::OP_GATE_OFF));      // not gated: ignored
        offer(ctl_word(OP_UNUSED));
        offer(ctl_word(ladsr_pkg::OP_GATE_ON));
        foreach (edge_samples[i])
            offer(sample_word(edge_samples[i]));
        offer(ctl_word(ladsr_pkg::OP_GATE_ON));       // restart from zero mid-note
        offer(sample_word(24'h800000));
        offer(sample_word(24'h7FFFFF));
        offer(ctl_word(ladsr_pkg::OP_GATE_OFF));
        offer(ctl_word(ladsr_pkg::OP_GATE_OFF));      // already released: ignored
        for (int i = 0; i < 6; i++)
            offer(sample_word(edge_samples[i]));

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            if (phase == 0)
                prof = PROF_FLOOR;
            else if (phase == 1)
                prof = PROF_CEILING;
            else if (phase == 2)
                prof = PROF_UNITY;
            else
            begin
                r = $urandom_range(99);
                if (r < 50)
                    prof = PROF_BRISK;
                else if (r < 65)
                    prof = PROF_SLOW;
                else if (r < 85)
                    prof = PROF_WILD;
                else if (r < 90)
                    prof = PROF_FLOOR;
                else if (r < 95)
                    prof = PROF_CEILING;
                else
                    prof = PROF_UNITY;
            end
            case (prof)
                PROF_FLOOR:
                begin
                    atk = '0; dec = '0; rel = '0; sus = '0; gain = '0;
                end
                PROF_CEILING:
                begin
                    // sustain above one is clamped to one
                    atk = '1; dec = '1; rel = '1; sus = '1; gain = 24'h00FFFF;
                end
                PROF_UNITY:
                begin
                    atk = ladsr_pkg::UNITY_LEVEL; dec = ladsr_pkg::UNITY_LEVEL;
                    rel = ladsr_pkg::UNITY_LEVEL; sus = ladsr_pkg::UNITY_LEVEL;
                    gain = 24'(ladsr_pkg::GAIN_RESET);
                end
                PROF_BRISK:
                begin
                    atk  = 24'(ladsr_pkg::UNITY_LEVEL / $urandom_range(2, 24));
                    dec  = 24'(ladsr_pkg::UNITY_LEVEL / $urandom_range(2, 24));
                    rel  = 24'(ladsr_pkg::UNITY_LEVEL / $urandom_range(2, 24));
                    sus  = 24'($urandom_range(0, ladsr_pkg::UNITY_LEVEL));
                    gain = 24'($urandom_range(0, 65535));
                end
                PROF_SLOW:
                begin
                    atk  = 24'($urandom_range(1, 24'h20000));
                    dec  = 24'($urandom_range(1, 24'h20000));
                    rel  = 24'($urandom_range(1, 24'h20000));
                    sus  = 24'($urandom_range(0, ladsr_pkg::UNITY_LEVEL));
                    gain = 24'($urandom_range(0, 65535));
                end
                default:
                begin
                    atk = 24'($urandom); dec = 24'($urandom); rel = 24'($urandom);
                    sus = 24'($urandom); gain = 24'($urandom);
                end
            endcase
            program_envelope(atk, dec, rel, sus, gain, $urandom_range(3) == 0);

            if (phase % 4 == 1)
            begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_gap_pct = $urandom_range(5, 50);
                out_stall_pct = $urandom_range(5, 50);
            end
            // long output hold-off with the sender flat out: input must back up
            if (phase == 4 || $urandom_range(7) == 0)
            begin
                in_gap_pct = 0;
                hold_request = 1'b1;
            end

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                r = $urandom_range(99);
                if (r < 8)
                begin
                    offer(ctl_word(OP_UNUSED));
                end
                else if (r < 14)
                begin
                    offer(ctl_word(ladsr_pkg::OP_GATE_OFF));
                end
                else
                begin
                    offer(ctl_word(ladsr_pkg::OP_GATE_ON));
                    n_on = $urandom_range(1, 70);
                    for (int i = 0; i < n_on; i++)
                    begin
                        if ($urandom_range(19) == 0)
                            offer(ctl_word(ladsr_pkg::OP_GATE_ON));
                        offer(sample_word(random_sample()));
                    end
                    if ($urandom_range(9) != 0)
                        offer(ctl_word(ladsr_pkg::OP_GATE_OFF));
                    n_off = $urandom_range(0, 60);
                    for (int i = 0; i < n_off; i++)
                        offer(sample_word(random_sample()));
                end
            end
        end

        drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("linear_adsr_envelope test passed");
        else
            $display("linear_adsr_envelope test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ladsr_pkg.sv
rtl/linear_adsr_envelope.sv
bench/linear_adsr_envelope_tb.sv
